// File: rtl/adsr_pkg.sv
// Shared types and constants for the ADSR envelope block.
`default_nettype none

package adsr_pkg;

    localparam int unsigned ENV_W   = 23;
    localparam int unsigned FADE_W  = 24;
    localparam int unsigned REQ_W   = 3;
    localparam int unsigned STAGE_W = 3;
    localparam int unsigned VEL_W   = 7;
    localparam int unsigned WHEEL_W = 8;
    localparam int unsigned VOL_W   = 8;
    localparam int unsigned LEV_W   = 7;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 24;

    localparam logic [ENV_W-1:0] ENV_FULL = 23'h7F0000;
    localparam logic [ENV_W-1:0] CUT_RATE = 23'h060000;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_OFF    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CUT    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLOSE  = 3'd4;

    // Envelope stages
    localparam logic [STAGE_W-1:0] STG_ATTACK  = 3'd0;
    localparam logic [STAGE_W-1:0] STG_DECAY   = 3'd1;
    localparam logic [STAGE_W-1:0] STG_FADE    = 3'd2;
    localparam logic [STAGE_W-1:0] STG_RELEASE = 3'd3;
    localparam logic [STAGE_W-1:0] STG_CUT     = 3'd4;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_DECAY   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SUSTAIN = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_FADE    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_RELEASE = 3'd4;

    localparam logic [ENV_W-1:0]  RST_ATTACK  = 23'h010000;
    localparam logic [ENV_W-1:0]  RST_DECAY   = 23'h010000;
    localparam logic [ENV_W-1:0]  RST_SUSTAIN = 23'h400000;
    localparam logic [FADE_W-1:0] RST_FADE    = 24'h000000;
    localparam logic [ENV_W-1:0]  RST_RELEASE = 23'h010000;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture request fields and pre-update level
        logic step;   // apply request to envelope state, first multiply
        logic emit;   // second multiply, fill output register
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/adsr_ctrl.sv
// Sequencing controller: capture, step and emit phases plus output valid.
`default_nettype none

module adsr_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output adsr_pkg::t_cmd   o_cmd
);
    import adsr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register can take the result
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/adsr_dpath.sv
// Envelope state, configuration registers, volume multiplier and output register.
`default_nettype none

module adsr_dpath (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  adsr_pkg::t_cmd                 i_cmd,
    input  wire                            i_cfg_valid,
    input  wire  [adsr_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire  [adsr_pkg::CDATA_W-1:0]   i_cfg_data,
    input  wire  [adsr_pkg::REQ_W-1:0]     i_req_type,
    input  wire  [adsr_pkg::VEL_W-1:0]     i_velocity,
    input  wire  [adsr_pkg::WHEEL_W-1:0]   i_channel_volume,
    input  wire                            i_has_channel,
    output logic [adsr_pkg::VOL_W-1:0]     o_volume,
    output logic [adsr_pkg::ENV_W-1:0]     o_envelope,
    output logic [adsr_pkg::STAGE_W-1:0]   o_stage,
    output logic                           o_finished,
    output logic                           o_voice_active
);
    import adsr_pkg::*;

    localparam int unsigned P1_W = VEL_W + WHEEL_W;
    localparam int unsigned P2_W = P1_W + LEV_W;

    // configuration
    logic [ENV_W-1:0]  r_attack, r_decay, r_sustain, r_release;
    logic [FADE_W-1:0] r_fade;

    // envelope state
    logic [ENV_W-1:0]   r_env,   n_env;
    logic [STAGE_W-1:0] r_stage, n_stage;
    logic               r_active, n_active;
    logic               r_fin,   n_fin;

    // captured request
    logic [REQ_W-1:0]   r_req;
    logic [VEL_W-1:0]   r_vel;
    logic [WHEEL_W-1:0] r_wheel;
    logic               r_has_ch;
    logic [LEV_W-1:0]   r_lev;

    logic [P1_W-1:0]    r_p1;
    logic               r_vol_en;

    // arithmetic
    logic [ENV_W:0]          atk_sum;
    logic [ENV_W:0]          dec_thr;
    logic signed [ENV_W+1:0] fade_diff;
    logic [ENV_W-1:0]        rel_rate;
    logic [P2_W-1:0]         p2;
    logic [VOL_W-1:0]        vol;
    logic                    tick_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= RST_ATTACK;
            r_decay   <= RST_DECAY;
            r_sustain <= RST_SUSTAIN;
            r_fade    <= RST_FADE;
            r_release <= RST_RELEASE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ATTACK:  r_attack  <= i_cfg_data[ENV_W-1:0];
                CFG_DECAY:   r_decay   <= i_cfg_data[ENV_W-1:0];
                CFG_SUSTAIN: r_sustain <= i_cfg_data[ENV_W-1:0];
                CFG_FADE:    r_fade    <= i_cfg_data[FADE_W-1:0];
                CFG_RELEASE: r_release <= i_cfg_data[ENV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req_type;
            r_vel    <= i_velocity;
            r_wheel  <= i_channel_volume;
            r_has_ch <= i_has_channel;
            r_lev    <= r_env[ENV_W-1 -: LEV_W];
        end
    end

    assign tick_live = (r_req == REQ_TICK) && r_active;
    assign atk_sum   = {1'b0, r_env} + {1'b0, r_attack};
    assign dec_thr   = {1'b0, r_sustain} + {1'b0, r_decay};
    assign fade_diff = $signed({2'b00, r_env}) - $signed({r_fade[FADE_W-1], r_fade});
    assign rel_rate  = ((r_stage == STG_CUT) && (r_release == '0)) ? CUT_RATE : r_release;

    always_comb begin
        n_env    = r_env;
        n_stage  = r_stage;
        n_active = r_active;
        n_fin    = 1'b0;
        unique case (r_req)
            REQ_TICK: begin
                if (r_active) begin
                    case (r_stage) inside
                        STG_ATTACK: begin
                            if (atk_sum >= {1'b0, ENV_FULL}) begin
                                n_env   = ENV_FULL;
                                n_stage = STG_DECAY;
                            end else begin
                                n_env = atk_sum[ENV_W-1:0];
                            end
                        end
                        STG_DECAY: begin
                            if ({1'b0, r_env} <= dec_thr) begin
                                n_env   = r_sustain;
                                n_stage = STG_FADE;
                            end else begin
                                n_env = r_env - r_decay;
                            end
                        end
                        STG_FADE: begin
                            if (fade_diff >= $signed({2'b00, ENV_FULL})) begin
                                n_env = ENV_FULL;
                            end else if (fade_diff <= $signed({(ENV_W+2){1'b0}})) begin
                                n_env = '0;
                                n_fin = 1'b1;
                            end else begin
                                n_env = fade_diff[ENV_W-1:0];
                            end
                        end
                        STG_RELEASE, STG_CUT: begin
                            if (r_env <= rel_rate) begin
                                n_env = '0;
                                n_fin = 1'b1;
                            end else begin
                                n_env = r_env - rel_rate;
                            end
                        end
                        default: ;
                    endcase
                    if (n_fin) begin
                        n_active = 1'b0;
                    end
                end
            end
            REQ_START: begin
                n_stage  = STG_ATTACK;
                n_env    = '0;
                n_active = 1'b1;
            end
            REQ_OFF: begin
                if (r_active) begin
                    n_stage = STG_RELEASE;
                end
            end
            REQ_CUT: begin
                if (r_active) begin
                    // a silent channel turns the cut into a close
                    if (r_has_ch && (r_wheel == '0)) begin
                        n_stage = STG_RELEASE;
                        n_env   = '0;
                    end else begin
                        n_stage = STG_CUT;
                    end
                end
            end
            REQ_CLOSE: begin
                if (r_active) begin
                    n_stage = STG_RELEASE;
                    n_env   = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env    <= '0;
            r_stage  <= STG_ATTACK;
            r_active <= 1'b0;
        end else if (i_cmd.step) begin
            r_env    <= n_env;
            r_stage  <= n_stage;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_fin    <= n_fin;
            r_vol_en <= tick_live;
            r_p1     <= r_has_ch ? (P1_W'(r_wheel) * P1_W'(r_vel)) : P1_W'(r_vel);
        end
    end

    assign p2  = P2_W'(r_p1) * P2_W'(r_lev);
    assign vol = r_has_ch ? p2[14 +: VOL_W] : p2[7 +: VOL_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_volume       <= r_vol_en ? vol : '0;
            o_envelope     <= r_env;
            o_stage        <= r_stage;
            o_finished     <= r_fin;
            o_voice_active <= r_active;
        end
    end

endmodule

`default_nettype wire

// File: rtl/adsr_envelope_with_volume.sv
// Top level of the single-voice ADSR envelope generator with volume output.
//
// Each request is first captured with the envelope level as it stood, then
// applied to the envelope state while the first volume product is formed, and
// last the second product fills the output register when free. The two-step
// multiply and the shared envelope state set that order; a new request is
// taken as soon as the last result sits in the output register, even while it
// is stalled. A tick of an active voice gives the volume from the level before
// the step; other requests report volume zero. Configuration writes are always
// ready and must only be issued while no request is in flight.
`default_nettype none

module adsr_envelope_with_volume (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [adsr_pkg::REQ_W-1:0]     i_req_type,
    input  wire  [adsr_pkg::VEL_W-1:0]     i_velocity,
    input  wire  [adsr_pkg::WHEEL_W-1:0]   i_channel_volume,
    input  wire                            i_has_channel,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [adsr_pkg::VOL_W-1:0]     o_volume,
    output logic [adsr_pkg::ENV_W-1:0]     o_envelope,
    output logic [adsr_pkg::STAGE_W-1:0]   o_stage,
    output logic                           o_finished,
    output logic                           o_voice_active,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [adsr_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire  [adsr_pkg::CDATA_W-1:0]   i_cfg_data
);
    import adsr_pkg::*;

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    adsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    adsr_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_valid      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_req_type       (i_req_type),
        .i_velocity       (i_velocity),
        .i_channel_volume (i_channel_volume),
        .i_has_channel    (i_has_channel),
        .o_volume         (o_volume),
        .o_envelope       (o_envelope),
        .o_stage          (o_stage),
        .o_finished       (o_finished),
        .o_voice_active   (o_voice_active)
    );

endmodule

`default_nettype wire

// File: rtl/adsr_checker.sv
// Port-level checks for the ADSR envelope block, bound to the top level.
`default_nettype none

module adsr_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_in_valid,
    input wire                            o_in_stall,
    input wire                            o_out_valid,
    input wire                            i_out_stall,
    input wire [adsr_pkg::VOL_W-1:0]      o_volume,
    input wire [adsr_pkg::ENV_W-1:0]      o_envelope,
    input wire [adsr_pkg::STAGE_W-1:0]    o_stage,
    input wire                            o_finished,
    input wire                            o_voice_active
);
    import adsr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_volume)
            && $stable(o_envelope) && $stable(o_stage))
        else $error("stalled result changed");

    // one request at a time: stall right after an accept
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    // finishing leaves the voice silent at zero
    a_fin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_finished |-> !o_voice_active && (o_envelope == '0))
        else $error("finished with live envelope");

    // a sounding volume comes only from a live voice
    a_vol_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_volume != '0) |-> o_voice_active || o_finished)
        else $error("volume from idle voice");

endmodule

bind adsr_envelope_with_volume adsr_checker u_adsr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_volume       (o_volume),
    .o_envelope     (o_envelope),
    .o_stage        (o_stage),
    .o_finished     (o_finished),
    .o_voice_active (o_voice_active)
);

`default_nettype wire
